// ===== rtl/core/psth_pkg.sv =====
// ----------------------------------------------------------------------------
// psth_pkg
// Shared types and constants for the probabilistic sample/track-and-hold core.
// ----------------------------------------------------------------------------
package psth_pkg;

    localparam int CHANNELS = 16;
    localparam int CH_W     = $clog2(CHANNELS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_MODE      = 3'd0,
        CFG_SAMPLE_ON_HIGH = 3'd1,
        CFG_PROBABILITY    = 3'd2,
        CFG_SCALE_GAIN     = 3'd3,
        CFG_OFFSET_LEVEL   = 3'd4
    } t_cfg_idx;

    localparam logic signed [15:0] GATE_HIGH = 16'sd2048;
    localparam logic signed [15:0] OUT_MAX   = 16'sd20480;
    localparam logic signed [15:0] OUT_MIN   = -16'sd20480;

    localparam logic [16:0]        PROB_RESET  = 17'd65536;
    localparam logic signed [15:0] GAIN_RESET  = 16'sd32767;

    typedef struct packed {
        logic [3:0]         channel_index;
        logic signed [15:0] trigger_level;
        logic signed [15:0] signal_sample;
        logic [15:0]        chance_draw;
    } t_in_req;

    typedef struct packed {
        logic [3:0]         out_channel;
        logic signed [15:0] held_output;
    } t_out_req;

endpackage

// ===== rtl/core/psth_scale.sv =====
// ----------------------------------------------------------------------------
// psth_scale
// gain * signal + offset, rounded half up to Q5.11 and clamped to +/-10 V.
// ----------------------------------------------------------------------------
module psth_scale (
    input  logic signed [15:0] i_signal,
    input  logic signed [15:0] i_gain,
    input  logic signed [15:0] i_offset,
    output logic signed [15:0] o_value
);

    logic signed [31:0] prod;
    logic signed [32:0] sum;
    logic signed [17:0] quo;
    logic signed [17:0] max_x;
    logic signed [17:0] min_x;

    assign prod  = 32'(i_signal) * 32'(i_gain);
    assign sum   = $signed({prod[31], prod})
                 + $signed({{2{i_offset[15]}}, i_offset, 15'd0})
                 + 33'sd16384;
    assign quo   = sum[32:15];
    assign max_x = {{2{psth_pkg::OUT_MAX[15]}}, psth_pkg::OUT_MAX};
    assign min_x = {{2{psth_pkg::OUT_MIN[15]}}, psth_pkg::OUT_MIN};

    always_comb begin
        if (quo > max_x) begin
            o_value = psth_pkg::OUT_MAX;
        end else if (quo < min_x) begin
            o_value = psth_pkg::OUT_MIN;
        end else begin
            o_value = quo[15:0];
        end
    end

endmodule

// ===== rtl/core/probabilistic_sample_track_hold_core.sv =====
// ----------------------------------------------------------------------------
// probabilistic_sample_track_hold_core
// Per-channel probabilistic sample-and-hold / track-and-hold, one track.
//
//   channel | direction | payload            | handshake
//   in      | input     | psth_pkg::t_in_req  | i_in_valid / o_in_ready
//   out     | output    | psth_pkg::t_out_req | o_out_valid / i_out_ready
//   cfg     | input     | 17-bit data, 3-bit idx | i_cfg_we, no wait
//
// Result is registered in r_out after r_in; one request per cycle unless stalled.
// Channel state is read, updated and written back in the single compute
// stage, so consecutive requests on one channel need no bypass.
// Stalls on the output hold the input register and drop o_in_ready.
// Synchronous active-low reset clears channel state and loads register defaults.
// ----------------------------------------------------------------------------
module probabilistic_sample_track_hold_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  psth_pkg::t_in_req                      i_in_req,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output psth_pkg::t_out_req                     o_out_req,
    input  logic                                   i_cfg_we,
    input  logic [psth_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [psth_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic                     r_hold_mode;
    logic                     r_sample_high;
    logic [16:0]              r_probability;
    logic signed [15:0]       r_gain;
    logic signed [15:0]       r_offset;

    logic [psth_pkg::CHANNELS-1:0] r_gate_was_high;
    logic [psth_pkg::CHANNELS-1:0] r_hold_flag;
    logic signed [15:0]            r_value [psth_pkg::CHANNELS];

    logic                r_in_valid;
    psth_pkg::t_in_req   r_in;
    logic                r_out_valid;
    psth_pkg::t_out_req  r_out;

    logic                       advance;
    logic                       fire;
    logic [psth_pkg::CH_W-1:0]  ch;
    logic                       high;
    logic                       rising;
    logic                       accept;
    logic signed [15:0]         sampled;
    logic                       n_hold;
    logic signed [15:0]         n_value;

    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign fire        = r_in_valid && advance;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    assign ch     = r_in.channel_index[psth_pkg::CH_W-1:0];
    assign high   = r_in.trigger_level >= psth_pkg::GATE_HIGH;
    assign rising = high && !r_gate_was_high[ch];
    assign accept = r_probability >= {1'b0, r_in.chance_draw};

    psth_scale u_scale (
        .i_signal (r_in.signal_sample),
        .i_gain   (r_gain),
        .i_offset (r_offset),
        .o_value  (sampled)
    );

    always_comb begin
        n_hold  = r_hold_flag[ch];
        n_value = r_value[ch];
        if (!r_hold_mode) begin
            if (rising && accept) begin
                n_value = sampled;
            end
        end else if (!r_sample_high) begin
            if (rising) begin
                if (accept) begin
                    n_value = sampled;
                    n_hold  = 1'b0;
                end
            end else if (high) begin
                if (!n_hold) begin
                    n_value = sampled;
                end
            end else if (!n_hold) begin
                n_hold  = 1'b1;
                n_value = sampled;
            end
        end else begin
            if (rising) begin
                n_hold = accept;
            end else if (!high) begin
                n_hold = 1'b0;
            end
            if (!n_hold || (rising && accept)) begin
                n_value = sampled;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_gate_was_high <= '0;
            r_hold_flag     <= '0;
            for (int i = 0; i < psth_pkg::CHANNELS; i++) begin
                r_value[i] <= '0;
            end
            r_hold_mode   <= 1'b0;
            r_sample_high <= 1'b0;
            r_probability <= psth_pkg::PROB_RESET;
            r_gain        <= psth_pkg::GAIN_RESET;
            r_offset      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_in <= i_in_req;
                end
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_out.out_channel  <= r_in.channel_index;
                r_out.held_output  <= n_value;
                r_value[ch]         <= n_value;
                r_hold_flag[ch]     <= n_hold;
                r_gate_was_high[ch] <= high;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    psth_pkg::CFG_HOLD_MODE: begin
                        r_hold_mode <= i_cfg_data[0];
                    end
                    psth_pkg::CFG_SAMPLE_ON_HIGH: begin
                        r_sample_high <= i_cfg_data[0];
                        r_hold_flag   <= {psth_pkg::CHANNELS{i_cfg_data[0]}};
                    end
                    psth_pkg::CFG_PROBABILITY: begin
                        r_probability <= i_cfg_data[16:0];
                    end
                    psth_pkg::CFG_SCALE_GAIN: begin
                        r_gain <= i_cfg_data[15:0];
                    end
                    psth_pkg::CFG_OFFSET_LEVEL: begin
                        r_offset <= i_cfg_data[15:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    a_out_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.held_output <= psth_pkg::OUT_MAX
                      && r_out.held_output >= psth_pkg::OUT_MIN))
        else $error("held output outside clamp range");

    a_in_reg_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("input register changed while stalled");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a pending request");

    a_cfg_hold_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == psth_pkg::CFG_SAMPLE_ON_HIGH
        |=> r_hold_flag == {psth_pkg::CHANNELS{$past(i_cfg_data[0])}})
        else $error("hold flags not set by gate-sense write");

endmodule

// ===== tb/probabilistic_sample_track_hold_core_tb.sv =====
// ----------------------------------------------------------------------------
// probabilistic_sample_track_hold_core_tb
// Self-checking bench for the probabilistic sample/track-and-hold core.
// A queue of requests feeds a valid/ready driver. Each accepted request runs
// through a local model of the per-channel gate, hold and level state. The
// predicted output is queued and compared field by field with what the
// monitor sees. A directed pass covers the gate threshold, clamping, draw
// acceptance and both hold modes. Random phases follow, each with its own
// register settings; in all but the last two, both sides idle at random.
// ----------------------------------------------------------------------------
module probabilistic_sample_track_hold_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PHASES    = 7;
    localparam int PHASE_REQS     = 250;
    localparam int LONG_HOLD      = 60;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_LIMIT    = 2000;

    logic                            i_clk     = 1'b0;
    logic                            i_rst_n   = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    psth_pkg::t_in_req               in_req    = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    psth_pkg::t_out_req              out_req;
    logic                            cfg_we    = 1'b0;
    logic [psth_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [psth_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    psth_pkg::t_in_req  sample_reqs_q[$];
    psth_pkg::t_out_req held_values_q[$];

    int unsigned send_idle_pct = 14;
    int unsigned recv_idle_pct = 80;
    logic        long_hold_req = 1'b0;
    int          stall_left    = 0;
    int          mismatch_count = 0;

    // model state
    logic               cfg_track_mode  = 1'b0;
    logic               cfg_freeze_high = 1'b0;
    logic [16:0]        cfg_prob        = psth_pkg::PROB_RESET;
    logic signed [15:0] cfg_gain        = psth_pkg::GAIN_RESET;
    logic signed [15:0] cfg_offset      = '0;
    bit                 gate_seen_high [psth_pkg::CHANNELS];
    bit                 hold_active    [psth_pkg::CHANNELS];
    logic signed [15:0] channel_level  [psth_pkg::CHANNELS];
    bit                 gen_gate       [psth_pkg::CHANNELS];

    probabilistic_sample_track_hold_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [15:0] scaled_level(logic signed [15:0] sig);
        longint acc;
        acc = longint'(sig) * longint'(cfg_gain) + longint'(cfg_offset) * 32768 + 16384;
        acc = acc >>> 15;
        if (acc > psth_pkg::OUT_MAX) begin
            acc = psth_pkg::OUT_MAX;
        end else if (acc < psth_pkg::OUT_MIN) begin
            acc = psth_pkg::OUT_MIN;
        end
        return 16'(acc);
    endfunction

    function automatic psth_pkg::t_out_req next_held_output(psth_pkg::t_in_req r);
        int unsigned        ch;
        bit                 high;
        bit                 rising;
        bit                 accept;
        psth_pkg::t_out_req res;
        ch     = r.channel_index;
        high   = r.trigger_level >= psth_pkg::GATE_HIGH;
        rising = high && !gate_seen_high[ch];
        accept = cfg_prob >= {1'b0, r.chance_draw};
        if (!cfg_track_mode) begin
            if (rising && accept) channel_level[ch] = scaled_level(r.signal_sample);
        end else if (!cfg_freeze_high) begin
            if (rising) begin
                if (accept) begin
                    channel_level[ch] = scaled_level(r.signal_sample);
                    hold_active[ch]   = 1'b0;
                end
            end else if (high) begin
                if (!hold_active[ch]) channel_level[ch] = scaled_level(r.signal_sample);
            end else if (!hold_active[ch]) begin
                hold_active[ch]   = 1'b1;
                channel_level[ch] = scaled_level(r.signal_sample);
            end
        end else begin
            if (rising) begin
                if (accept) begin
                    hold_active[ch]   = 1'b1;
                    channel_level[ch] = scaled_level(r.signal_sample);
                end else begin
                    hold_active[ch] = 1'b0;
                end
            end else if (!high) begin
                hold_active[ch] = 1'b0;
            end
            if (!hold_active[ch]) channel_level[ch] = scaled_level(r.signal_sample);
        end
        gate_seen_high[ch] = high;
        res.out_channel = r.channel_index;
        res.held_output = channel_level[ch];
        return res;
    endfunction

    // request driver
    always @(posedge i_clk) begin : req_driver
        logic fire;
        fire = in_valid && in_ready;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (fire) held_values_q.push_back(next_held_output(in_req));
            if (in_valid && !fire) begin
                // hold request until taken
            end else if (sample_reqs_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_req   <= sample_reqs_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output backpressure
    always @(posedge i_clk) begin : out_monitor
        psth_pkg::t_out_req want;
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (held_values_q.size() == 0) begin
                    $error("unexpected result: channel %0d, held_output %0d",
                           out_req.out_channel, out_req.held_output);
                    mismatch_count++;
                end else begin
                    want = held_values_q.pop_front();
                    if (out_req.out_channel !== want.out_channel) begin
                        $error("out_channel: expected %0d, actual %0d",
                               want.out_channel, out_req.out_channel);
                        mismatch_count++;
                    end
                    if (out_req.held_output !== want.held_output) begin
                        $error("held_output: expected %0d, actual %0d",
                               want.held_output, out_req.held_output);
                        mismatch_count++;
                    end
                end
            end
            if (long_hold_req) begin
                stall_left <= LONG_HOLD;
                out_ready  <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic add_req(input int ch, input int trig, input int sig, input int draw);
        psth_pkg::t_in_req r;
        r.channel_index = 4'(ch);
        r.trigger_level = 16'(trig);
        r.signal_sample = 16'(sig);
        r.chance_draw   = 16'(draw);
        sample_reqs_q.push_back(r);
    endtask

    task automatic add_random_req();
        int unsigned ch;
        int          trig;
        int          sig;
        int          draw;
        ch = $urandom_range(1) ? $urandom_range(3) : $urandom_range(psth_pkg::CHANNELS - 1);
        if ($urandom_range(99) < 12) begin
            trig = int'($urandom_range(65535)) - 32768;
        end else begin
            if ($urandom_range(99) < 45) gen_gate[ch] = !gen_gate[ch];
            if ($urandom_range(3) == 0) begin
                trig = gen_gate[ch] ? 2048 : 2047;
            end else if (gen_gate[ch]) begin
                trig = int'($urandom_range(32767, 2048));
            end else begin
                trig = int'($urandom_range(34815)) - 32768;
            end
        end
        if ($urandom_range(9) == 0) begin
            sig = $urandom_range(1) ? 32767 : -32768;
        end else begin
            sig = int'($urandom_range(65535));
        end
        if ($urandom_range(9) == 0) begin
            draw = $urandom_range(1) ? 65535 : 0;
        end else begin
            draw = int'($urandom_range(65535));
        end
        add_req(ch, trig, sig, draw);
    endtask

    task automatic wait_drained();
        while (sample_reqs_q.size() != 0 || in_valid || held_values_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input psth_pkg::t_cfg_idx idx,
                             input logic [psth_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
    endtask

    task automatic program_settings(input bit mode, input bit freeze_high, input int prob,
                                    input int gain, input int offset);
        wait_drained();
        cfg_track_mode  = mode;
        cfg_freeze_high = freeze_high;
        cfg_prob        = 17'(prob);
        cfg_gain        = 16'(gain);
        cfg_offset      = 16'(offset);
        foreach (hold_active[c]) hold_active[c] = freeze_high;
        write_reg(psth_pkg::CFG_HOLD_MODE,      {16'd0, mode});
        write_reg(psth_pkg::CFG_SAMPLE_ON_HIGH, {16'd0, freeze_high});
        write_reg(psth_pkg::CFG_PROBABILITY,    17'(prob));
        write_reg(psth_pkg::CFG_SCALE_GAIN,     {1'b0, 16'(gain)});
        write_reg(psth_pkg::CFG_OFFSET_LEVEL,   {1'b0, 16'(offset)});
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int prob;
        int gain;
        int offset;
        int drain;
        foreach (channel_level[c]) begin
            gate_seen_high[c] = 1'b0;
            hold_active[c]    = 1'b0;
            channel_level[c]  = '0;
            gen_gate[c]       = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: sample and hold, always accept, unity gain
        add_req(0, 0, 1000, 0);
        add_req(0, 2048, 32767, 65535);
        add_req(0, 32767, 0, 0);
        add_req(0, 2047, 0, 0);
        add_req(0, 2048, -32768, 0);
        add_req(15, -32768, 5, 0);
        add_req(15, 2048, 4096, 12345);

        // zero probability: only a zero draw passes; negative full gain
        program_settings(1'b0, 1'b0, 0, -32768, 20480);
        add_req(1, 4096, 100, 0);
        add_req(2, 4096, 100, 1);
        add_req(3, 4096, -32768, 0);

        // track on high gate, freeze on low
        program_settings(1'b1, 1'b0, 32768, 16384, -20480);
        add_req(4, 0, 2000, 0);
        add_req(4, 0, 3000, 0);
        add_req(4, 2048, 4000, 40000);
        add_req(4, 2048, 5000, 0);
        add_req(4, 0, 5500, 0);
        add_req(4, 3000, 6000, 32768);
        add_req(4, 3000, 7000, 65535);

        // freeze on high gate, track on low
        program_settings(1'b1, 1'b1, 65536, 32767, 0);
        add_req(5, 0, 100, 0);
        add_req(5, 5000, 200, 65535);
        add_req(5, 5000, 300, 0);
        add_req(6, 5000, 400, 0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin prob = 65536; gain = 32767;  offset = 0;      end
                1: begin prob = 32768; gain = -32768; offset = 20480;  end
                2: begin prob = 0;     gain = 16384;  offset = -20480; end
                default: begin
                    prob   = int'($urandom_range(65536));
                    gain   = int'($urandom_range(65535)) - 32768;
                    offset = int'($urandom_range(40960)) - 20480;
                end
            endcase
            program_settings(p[0] ^ p[1], p[1], prob, gain, offset);
            if (p >= 5) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end else if (p >= 3) begin
                send_idle_pct <= 80;
                recv_idle_pct <= 14;
            end
            repeat (PHASE_REQS) add_random_req();
            if (p == 5) begin
                @(posedge i_clk);
                long_hold_req <= 1'b1;
                @(posedge i_clk);
                long_hold_req <= 1'b0;
            end
        end

        while (sample_reqs_q.size() != 0 || in_valid) @(posedge i_clk);
        drain = 0;
        while (held_values_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (held_values_q.size() != 0) begin
            $error("%0d results never arrived", held_values_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/psth_pkg.sv
rtl/core/psth_scale.sv
rtl/core/probabilistic_sample_track_hold_core.sv
tb/probabilistic_sample_track_hold_core_tb.sv
